// ===== src/jads_pkg.sv =====
// ----------------------------------------------------------------------------
// jads_pkg
// Shared types and constants for the joystick axis deadzone scaler: widths,
// reset values, register indexes, controller states and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package jads_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int CAL_SAMPLES_DEF = 32;
    localparam int PCT_W           = 8;
    localparam int MAG_W           = 7;
    localparam int CFG_IDX_W       = 2;

    localparam logic [MAG_W-1:0]       PCT_FULL     = 7'd100;
    localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = 12'd2048;
    localparam logic [SAMPLE_BITS-1:0] DZ_RESET     = 12'd100;
    localparam logic [SAMPLE_BITS-1:0] FS_RESET     = 12'd4095;

    // input word commands
    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE        = 2'd0,
        REG_ADC_FULL_SCALE  = 2'd1,
        REG_INVERT_STEERING = 2'd2,
        REG_INVERT_THROTTLE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic axis;
        logic div_start;
        logic store_direct;
        logic store_quot;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_cal;
        logic cal_full;
        logic need_div;
        logic div_done;
        logic out_busy;
    } dp_sts_t;

    // magnitude 0..100 with sign and optional inversion, as an 8 bit percentage
    function automatic logic signed [PCT_W-1:0] pct_apply(
        input logic [MAG_W-1:0] mag,
        input logic             neg,
        input logic             inv
    );
        logic signed [PCT_W-1:0] v;
        v = $signed({1'b0, mag});
        if (neg ^ inv)
        begin
            v = -v;
        end
        return v;
    endfunction

endpackage

// ===== src/jads_div.sv =====
// ----------------------------------------------------------------------------
// jads_div
// Iterative unsigned restoring divider, two quotient bits per cycle. Divisor
// must be nonzero. Quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module jads_div #(
    parameter int DIV_W = 20,
    parameter int DVS_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   r1, r2, d_ext;
    logic             ge1, ge2;
    logic [DVS_W-1:0] rem1;

    always_comb
    begin
        d_ext    = {1'b0, dvs_reg};
        r1       = {rem_reg, quo_reg[DIV_W-1]};
        ge1      = (r1 >= d_ext);
        rem1     = ge1 ? DVS_W'(r1 - d_ext) : DVS_W'(r1);
        r2       = {rem1, quo_reg[DIV_W-2]};
        ge2      = (r2 >= d_ext);
        rem_next = ge2 ? DVS_W'(r2 - d_ext) : DVS_W'(r2);
        quo_next = {quo_reg[DIV_W-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/jads_datapath.sv =====
// ----------------------------------------------------------------------------
// jads_datapath
// Item, configuration, calibration and output registers, per-axis operand
// setup and the shared divider for centres and percentages.
// ----------------------------------------------------------------------------
module jads_datapath #(
    parameter int CAL_SAMPLES = jads_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jads_pkg::dp_cmd_t                   dp_cmd,
    output jads_pkg::dp_sts_t                   dp_sts,
    input  logic                                cmd,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_x,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_y,
    input  logic                                button_pin,
    input  logic                                cfg_write,
    input  logic [jads_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [jads_pkg::SAMPLE_BITS-1:0]    pass_x,
    output logic [jads_pkg::SAMPLE_BITS-1:0]    pass_y,
    output logic signed [jads_pkg::PCT_W-1:0]   steering,
    output logic signed [jads_pkg::PCT_W-1:0]   throttle,
    output logic                                button_down,
    output logic                                centre_updated
);
    import jads_pkg::*;

    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int NUM_W   = SAMPLE_BITS + MAG_W;
    localparam int DIV_RAW = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DIV_W   = DIV_RAW + (DIV_RAW % 2);
    localparam int DW      = SAMPLE_BITS + 2;

    // configuration
    logic [SAMPLE_BITS-1:0] dz_reg, fs_reg;
    logic                   inv_steer_reg, inv_thr_reg;

    // current item
    logic                   cmd_reg, pin_reg;
    logic [SAMPLE_BITS-1:0] x_reg, y_reg;

    // calibration state
    logic [SAMPLE_BITS-1:0] cx_reg, cy_reg;
    logic [SUM_W-1:0]       sx_reg, sy_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // per-item results
    logic signed [PCT_W-1:0] px_reg, py_reg;
    logic                    upd_reg;
    logic                    neg_reg, inv_reg;

    // output register
    logic                    ov_reg;
    logic [SAMPLE_BITS-1:0]  ox_reg, oy_reg;
    logic signed [PCT_W-1:0] osteer_reg, othr_reg;
    logic                    obtn_reg, oupd_reg;

    // axis operand setup
    logic [SAMPLE_BITS-1:0]  code, centre;
    logic [SUM_W-1:0]        sum;
    logic signed [DW-1:0]    diff, dz_s, span, span_p, span_n, dist_s;
    logic                    in_zone, pos, span_ok, inv_sel;
    logic [SAMPLE_BITS-1:0]  dist_u, span_u;
    logic [NUM_W-1:0]        num;
    logic [DIV_W-1:0]        dividend, quotient;
    logic [SAMPLE_BITS-1:0]  divisor;
    logic                    div_done;
    logic [MAG_W-1:0]        mag_direct, mag_quot;
    logic signed [PCT_W-1:0] pct_direct, pct_quot;
    logic [CNT_W:0]          cnt_inc;

    always_comb
    begin
        code    = dp_cmd.axis ? y_reg : x_reg;
        centre  = dp_cmd.axis ? cy_reg : cx_reg;
        sum     = dp_cmd.axis ? sy_reg : sx_reg;
        inv_sel = dp_cmd.axis ? inv_thr_reg : inv_steer_reg;

        dz_s    = $signed({2'b00, dz_reg});
        diff    = $signed({2'b00, code}) - $signed({2'b00, centre});
        in_zone = (diff >= -dz_s) && (diff <= dz_s);
        pos     = (diff > 0);
        span_p  = $signed({2'b00, fs_reg}) - $signed({2'b00, centre}) - dz_s;
        span_n  = $signed({2'b00, centre}) - dz_s;
        span    = pos ? span_p : span_n;
        span_ok = (span > 0);
        span_u  = span[SAMPLE_BITS-1:0];
        dist_s  = pos ? (diff - dz_s) : (-diff - dz_s);
        dist_u  = dist_s[SAMPLE_BITS-1:0];
        num     = NUM_W'(dist_u) * NUM_W'(PCT_FULL);

        dividend = cmd_reg ? DIV_W'(sum) : DIV_W'(num);
        divisor  = cmd_reg ? SAMPLE_BITS'(CAL_SAMPLES) : span_u;

        mag_direct = in_zone ? '0 : PCT_FULL;
        pct_direct = pct_apply(mag_direct, !pos, inv_sel);
        mag_quot   = (quotient > DIV_W'(PCT_FULL)) ? PCT_FULL : quotient[MAG_W-1:0];
        pct_quot   = pct_apply(mag_quot, neg_reg, inv_reg);

        cnt_inc = {1'b0, cnt_reg} + 1'b1;
    end

    jads_div #(
        .DIV_W (DIV_W),
        .DVS_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dp_cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        dp_sts.is_cal   = cmd_reg;
        dp_sts.cal_full = (cnt_inc == (CNT_W + 1)'(CAL_SAMPLES));
        dp_sts.need_div = cmd_reg || (!in_zone && span_ok);
        dp_sts.div_done = div_done;
        dp_sts.out_busy = ov_reg && !out_ready;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg        <= DZ_RESET;
            fs_reg        <= FS_RESET;
            inv_steer_reg <= 1'b0;
            inv_thr_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DEADZONE:        dz_reg        <= cfg_data;
                REG_ADC_FULL_SCALE:  fs_reg        <= cfg_data;
                REG_INVERT_STEERING: inv_steer_reg <= cfg_data[0];
                REG_INVERT_THROTTLE: inv_thr_reg   <= cfg_data[0];
                default:             dz_reg        <= dz_reg;
            endcase
        end
    end

    // calibration state and centres
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= CENTRE_RESET;
            cy_reg  <= CENTRE_RESET;
            sx_reg  <= '0;
            sy_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (dp_cmd.accum)
        begin
            sx_reg  <= sx_reg + SUM_W'(x_reg);
            sy_reg  <= sy_reg + SUM_W'(y_reg);
            cnt_reg <= cnt_inc[CNT_W-1:0];
        end
        else if (dp_cmd.store_quot && cmd_reg)
        begin
            if (dp_cmd.axis)
            begin
                cy_reg  <= quotient[SAMPLE_BITS-1:0];
                // both centres done, restart the run
                sx_reg  <= '0;
                sy_reg  <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                cx_reg <= quotient[SAMPLE_BITS-1:0];
            end
        end
    end

    // item and per-item result registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= cmd;
            x_reg   <= sample_x;
            y_reg   <= sample_y;
            pin_reg <= button_pin;
            px_reg  <= '0;
            py_reg  <= '0;
            upd_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.div_start)
            begin
                neg_reg <= !pos;
                inv_reg <= inv_sel;
            end
            if (dp_cmd.store_direct)
            begin
                if (dp_cmd.axis)
                    py_reg <= pct_direct;
                else
                    px_reg <= pct_direct;
            end
            if (dp_cmd.store_quot)
            begin
                if (cmd_reg)
                    upd_reg <= dp_cmd.axis;
                else if (dp_cmd.axis)
                    py_reg <= pct_quot;
                else
                    px_reg <= pct_quot;
            end
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (dp_cmd.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            ox_reg     <= x_reg;
            oy_reg     <= y_reg;
            osteer_reg <= px_reg;
            othr_reg   <= py_reg;
            obtn_reg   <= !pin_reg;
            oupd_reg   <= upd_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign pass_x         = ox_reg;
    assign pass_y         = oy_reg;
    assign steering       = osteer_reg;
    assign throttle       = othr_reg;
    assign button_down    = obtn_reg;
    assign centre_updated = oupd_reg;

endmodule

// ===== src/jads_ctrl.sv =====
// ----------------------------------------------------------------------------
// jads_ctrl
// Sequencer: takes one input word, runs calibration or the two axis
// conversions through the shared divider, then hands the word to the output.
// ----------------------------------------------------------------------------
module jads_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output jads_pkg::dp_cmd_t   dp_cmd,
    input  jads_pkg::dp_sts_t   dp_sts
);
    import jads_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        dp_cmd     = '0;
        dp_cmd.axis = axis_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                dp_cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                axis_next = 1'b0;
                if (dp_sts.is_cal)
                begin
                    dp_cmd.accum = 1'b1;
                    state_next   = dp_sts.cal_full ? ST_PREP : ST_OUT;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (dp_sts.need_div)
                begin
                    dp_cmd.div_start = 1'b1;
                    state_next       = ST_DIV;
                end
                else
                begin
                    dp_cmd.store_direct = 1'b1;
                    axis_next           = 1'b1;
                    state_next          = axis_reg ? ST_OUT : ST_PREP;
                end
            end
            ST_DIV:
            begin
                if (dp_sts.div_done)
                begin
                    dp_cmd.store_quot = 1'b1;
                    axis_next         = 1'b1;
                    state_next        = axis_reg ? ST_OUT : ST_PREP;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!dp_sts.out_busy)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/joystick_axis_deadzone_scaler.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_deadzone_scaler
// Joystick X/Y deadzone and percentage scaler with centre calibration.
//
// Input channel (in_valid/in_ready) carries one word: cmd, sample_x,
// sample_y, button_pin. cmd 1 adds the pair into the calibration sums; every
// CAL_SAMPLES calibrate words the centres are recomputed and centre_updated
// is set on that word. cmd 0 converts both axes to -100..100 percent.
// Output channel (out_valid/out_ready) returns one word per input word, in
// order. Config channel (cfg_valid/cfg_ready, always ready) writes deadzone,
// adc_full_scale and the two invert bits by cfg_index; write only when idle.
// A calibrate word that does not complete a run goes from decode straight to
// the output state. A convert word takes each axis through a setup state
// and, outside the dead band with a positive span, through the shared
// two-bit-per-cycle divider; a centre update divides both sums. One word
// is in flight at a time; the next can be taken in the cycle after the
// result is loaded, while that result waits in the output register. If the
// receiver stalls, a finished word waits until the output register is free.
// Reset restores register defaults, centres of 2048 and clears the
// calibration run.
// ----------------------------------------------------------------------------
module joystick_axis_deadzone_scaler #(
    parameter int CAL_SAMPLES = jads_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_x,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_y,
    input  logic                                button_pin,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jads_pkg::SAMPLE_BITS-1:0]    pass_x,
    output logic [jads_pkg::SAMPLE_BITS-1:0]    pass_y,
    output logic signed [jads_pkg::PCT_W-1:0]   steering,
    output logic signed [jads_pkg::PCT_W-1:0]   throttle,
    output logic                                button_down,
    output logic                                centre_updated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jads_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    cfg_data
);
    import jads_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    jads_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts)
    );

    jads_datapath #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .cmd            (cmd),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .button_pin     (button_pin),
        .cfg_write      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .pass_x         (pass_x),
        .pass_y         (pass_y),
        .steering       (steering),
        .throttle       (throttle),
        .button_down    (button_down),
        .centre_updated (centre_updated)
    );

endmodule

// ===== sim/joystick_scaler_checker.sv =====
// ----------------------------------------------------------------------------
// joystick_scaler_checker
// Watches the input, output and config channels of the joystick axis
// deadzone scaler. Keeps its own copy of the registers, centres and
// calibration sums, predicts one result word per accepted input word and
// compares every accepted output word field by field, in order.
// ----------------------------------------------------------------------------
module joystick_scaler_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                cmd,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_x,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    sample_y,
    input  logic                                button_pin,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    pass_x,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    pass_y,
    input  logic signed [jads_pkg::PCT_W-1:0]   steering,
    input  logic signed [jads_pkg::PCT_W-1:0]   throttle,
    input  logic                                button_down,
    input  logic                                centre_updated,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [jads_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jads_pkg::SAMPLE_BITS-1:0]    cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jads_pkg::*;

    localparam int   MAX_PRINTS    = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]  px;
        logic [SAMPLE_BITS-1:0]  py;
        logic signed [PCT_W-1:0] steer;
        logic signed [PCT_W-1:0] thr;
        logic                    btn;
        logic                    upd;
    } joy_word_t;

    joy_word_t expected_words[$];

    logic [SAMPLE_BITS-1:0] dz_reg;
    logic [SAMPLE_BITS-1:0] fs_reg;
    logic                   inv_steer;
    logic                   inv_thr;
    logic [SAMPLE_BITS-1:0] centre_x;
    logic [SAMPLE_BITS-1:0] centre_y;
    int                     sum_x;
    int                     sum_y;
    int                     cal_count;
    int                     words_out;

    task automatic report_error(string msg);
        if (fail_count < MAX_PRINTS)
        begin
            $display("%0t ns: ERROR: %s", $time, msg);
        end
        fail_count++;
    endtask

    // deadzone, span on the side of the sample, truncation and saturation
    function automatic logic signed [PCT_W-1:0] axis_percent(
        logic [SAMPLE_BITS-1:0] code,
        logic [SAMPLE_BITS-1:0] ctr,
        logic                   inv
    );
        int dz;
        int diff;
        int span;
        int full;
        int v;
        dz   = int'(dz_reg);
        full = int'(PCT_FULL);
        diff = int'(code) - int'(ctr);
        if (diff >= -dz && diff <= dz)
        begin
            v = 0;
        end
        else if (diff > 0)
        begin
            span = int'(fs_reg) - int'(ctr) - dz;
            if (span <= 0)
            begin
                v = full;
            end
            else
            begin
                v = (diff - dz) * full / span;
                if (v > full)
                begin
                    v = full;
                end
            end
        end
        else
        begin
            span = int'(ctr) - dz;
            if (span <= 0)
            begin
                v = -full;
            end
            else
            begin
                v = (diff + dz) * full / span;
                if (v < -full)
                begin
                    v = -full;
                end
            end
        end
        if (inv)
        begin
            v = -v;
        end
        return v[PCT_W-1:0];
    endfunction

    function automatic joy_word_t predict_word(
        logic                   c,
        logic [SAMPLE_BITS-1:0] x,
        logic [SAMPLE_BITS-1:0] y,
        logic                   pin
    );
        joy_word_t w;
        w.px    = x;
        w.py    = y;
        w.steer = '0;
        w.thr   = '0;
        w.btn   = !pin;
        w.upd   = 1'b0;
        if (c == CMD_CALIBRATE)
        begin
            sum_x += int'(x);
            sum_y += int'(y);
            cal_count++;
            if (cal_count >= CAL_SAMPLES_DEF)
            begin
                centre_x  = SAMPLE_BITS'(sum_x / CAL_SAMPLES_DEF);
                centre_y  = SAMPLE_BITS'(sum_y / CAL_SAMPLES_DEF);
                sum_x     = 0;
                sum_y     = 0;
                cal_count = 0;
                w.upd     = 1'b1;
            end
        end
        else
        begin
            w.steer = axis_percent(x, centre_x, inv_steer);
            w.thr   = axis_percent(y, centre_y, inv_thr);
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        joy_word_t w;
        if (!rst_n)
        begin
            dz_reg     = DZ_RESET;
            fs_reg     = FS_RESET;
            inv_steer  = 1'b0;
            inv_thr    = 1'b0;
            centre_x   = CENTRE_RESET;
            centre_y   = CENTRE_RESET;
            sum_x      = 0;
            sum_y      = 0;
            cal_count  = 0;
            words_out  = 0;
            fail_count = 0;
            expected_words.delete();
            pending    = 0;
        end
        else
        begin
            // result side first, so a word can never match its own input
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_error($sformatf("output word %0d with nothing expected",
                                           words_out));
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (pass_x !== w.px)
                        report_error($sformatf("word %0d pass_x %0d, expected %0d",
                                               words_out, pass_x, w.px));
                    if (pass_y !== w.py)
                        report_error($sformatf("word %0d pass_y %0d, expected %0d",
                                               words_out, pass_y, w.py));
                    if (steering !== w.steer)
                        report_error($sformatf("word %0d steering %0d, expected %0d",
                                               words_out, steering, w.steer));
                    if (throttle !== w.thr)
                        report_error($sformatf("word %0d throttle %0d, expected %0d",
                                               words_out, throttle, w.thr));
                    if (button_down !== w.btn)
                        report_error($sformatf("word %0d button_down %b, expected %b",
                                               words_out, button_down, w.btn));
                    if (centre_updated !== w.upd)
                        report_error($sformatf("word %0d centre_updated %b, expected %b",
                                               words_out, centre_updated, w.upd));
                end
                words_out++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_DEADZONE:        dz_reg    = cfg_data;
                    REG_ADC_FULL_SCALE:  fs_reg    = cfg_data;
                    REG_INVERT_STEERING: inv_steer = cfg_data[0];
                    REG_INVERT_THROTTLE: inv_thr   = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                expected_words.push_back(predict_word(cmd, sample_x, sample_y, button_pin));
            end

            pending = expected_words.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the joystick axis deadzone scaler. A short
// directed run at the extremes and dead-band edges is followed by phases of
// random words, each with its own register setting and idle pattern:
// full calibration runs with random spread, broken runs, stray calibrate
// words and convert words aimed at the centre and the dead-band edges.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jads_pkg::*;

    localparam int   CODE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int   NUM_PHASES    = 8;
    localparam int   PHASE_WORDS   = 205;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_ready;
    logic                        cmd        = CMD_CONVERT;
    logic [SAMPLE_BITS-1:0]      sample_x   = '0;
    logic [SAMPLE_BITS-1:0]      sample_y   = '0;
    logic                        button_pin = 1'b1;
    logic                        out_valid;
    logic                        out_ready  = 1'b0;
    logic [SAMPLE_BITS-1:0]      pass_x;
    logic [SAMPLE_BITS-1:0]      pass_y;
    logic signed [PCT_W-1:0]     steering;
    logic signed [PCT_W-1:0]     throttle;
    logic                        button_down;
    logic                        centre_updated;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index  = REG_DEADZONE;
    logic [SAMPLE_BITS-1:0]      cfg_data   = '0;

    int fail_count;
    int pending;
    int send_idle  = 0;
    int recv_stall = 0;
    int dz_now     = int'(DZ_RESET);
    int aim_x      = int'(CENTRE_RESET);
    int aim_y      = int'(CENTRE_RESET);

    joystick_axis_deadzone_scaler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .button_pin     (button_pin),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pass_x         (pass_x),
        .pass_y         (pass_y),
        .steering       (steering),
        .throttle       (throttle),
        .button_down    (button_down),
        .centre_updated (centre_updated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    joystick_scaler_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .button_pin     (button_pin),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pass_x         (pass_x),
        .pass_y         (pass_y),
        .steering       (steering),
        .throttle       (throttle),
        .button_down    (button_down),
        .centre_updated (centre_updated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [SAMPLE_BITS-1:0] clamp_code(int v);
        if (v < 0)
            return '0;
        if (v > CODE_MAX)
            return SAMPLE_BITS'(CODE_MAX);
        return v[SAMPLE_BITS-1:0];
    endfunction

    // mostly around the current centre guess, with the dead-band edges hit hard
    function automatic logic [SAMPLE_BITS-1:0] pick_code(int aim);
        int d;
        int reach;
        reach = dz_now + 800;
        case ($urandom_range(7))
            0, 1: return SAMPLE_BITS'($urandom_range(CODE_MAX));
            2: return $urandom_range(1) ? SAMPLE_BITS'(CODE_MAX) : '0;
            3, 4:
            begin
                d = dz_now + int'($urandom_range(2)) - 1;
                return clamp_code($urandom_range(1) ? aim + d : aim - d);
            end
            default: return clamp_code(aim + int'($urandom_range(2 * reach)) - reach);
        endcase
    endfunction

    function automatic int pick_aim();
        case ($urandom_range(4))
            0: return 0;
            1: return CODE_MAX;
            default: return int'($urandom_range(3500, 600));
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that takes the word
    task automatic send_sample(
        logic                   c,
        logic [SAMPLE_BITS-1:0] x,
        logic [SAMPLE_BITS-1:0] y,
        logic                   pin
    );
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        sample_x   <= x;
        sample_y   <= y;
        button_pin <= pin;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [SAMPLE_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    initial
    begin
        int dz_tab[6]  = '{100, 0, 4095, 300, 250, 2048};
        int fs_tab[6]  = '{4095, 4095, 4095, 0, 1500, 2048};
        int ivs_tab[6] = '{0, 1, 0, 1, 0, 1};
        int ivt_tab[6] = '{0, 0, 1, 1, 0, 0};
        int ph;
        int sent;
        int n;
        int k;
        int r;
        int spread_x;
        int spread_y;
        int fs;
        int ivs;
        int ivt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: centre, dead-band edges, rails, button both ways
        send_sample(CMD_CONVERT, 12'd2048, 12'd2048, 1'b1);
        send_sample(CMD_CONVERT, 12'd2148, 12'd1948, 1'b0);
        send_sample(CMD_CONVERT, 12'd2149, 12'd1947, 1'b1);
        send_sample(CMD_CONVERT, 12'd0, 12'd4095, 1'b0);
        send_sample(CMD_CONVERT, 12'd4095, 12'd0, 1'b1);
        send_sample(CMD_CONVERT, 12'd3000, 12'd1000, 1'b0);
        send_sample(CMD_CONVERT, 12'd4095, 12'd4095, 1'b0);
        send_sample(CMD_CALIBRATE, 12'd4095, 12'd0, 1'b1);
        in_valid <= 1'b0;
        // one more edge so the checker has queued the last word
        @(posedge clk);
        wait (pending == 0);

        // no dead band, both axes negated
        write_reg(REG_DEADZONE, 12'd0);
        write_reg(REG_INVERT_STEERING, 12'd1);
        write_reg(REG_INVERT_THROTTLE, 12'd1);
        cfg_valid <= 1'b0;
        dz_now = 0;
        send_sample(CMD_CONVERT, 12'd2049, 12'd2047, 1'b1);
        send_sample(CMD_CONVERT, 12'd0, 12'd4095, 1'b0);
        send_sample(CMD_CONVERT, 12'd2048, 12'd1, 1'b1);
        send_sample(CMD_CONVERT, 12'd4094, 12'd2048, 1'b0);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            if (ph < 6)
            begin
                dz_now = dz_tab[ph];
                fs     = fs_tab[ph];
                ivs    = ivs_tab[ph];
                ivt    = ivt_tab[ph];
            end
            else
            begin
                dz_now = int'($urandom_range(400));
                fs     = int'($urandom_range(CODE_MAX, 1));
                ivs    = int'($urandom_range(1));
                ivt    = int'($urandom_range(1));
            end
            write_reg(REG_DEADZONE, SAMPLE_BITS'(dz_now));
            write_reg(REG_ADC_FULL_SCALE, SAMPLE_BITS'(fs));
            write_reg(REG_INVERT_STEERING, SAMPLE_BITS'(ivs));
            write_reg(REG_INVERT_THROTTLE, SAMPLE_BITS'(ivt));
            cfg_valid <= 1'b0;

            case (ph % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 77;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 77;
                end
                default:
                begin
                    send_idle  = 9;
                    recv_stall = 9;
                end
            endcase

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                r = int'($urandom_range(99));
                if (r < 12)
                begin
                    // calibration run, now and then cut short
                    n        = ($urandom_range(3) == 0) ? int'($urandom_range(31, 1))
                                                        : CAL_SAMPLES_DEF;
                    aim_x    = pick_aim();
                    aim_y    = pick_aim();
                    spread_x = int'($urandom_range(200));
                    spread_y = int'($urandom_range(200));
                    for (k = 0; k < n; k++)
                    begin
                        send_sample(CMD_CALIBRATE,
                            clamp_code(aim_x + int'($urandom_range(2 * spread_x)) - spread_x),
                            clamp_code(aim_y + int'($urandom_range(2 * spread_y)) - spread_y),
                            1'($urandom_range(1)));
                    end
                    sent += n;
                end
                else if (r < 17)
                begin
                    // stray calibrate word
                    send_sample(CMD_CALIBRATE, SAMPLE_BITS'($urandom_range(CODE_MAX)),
                                SAMPLE_BITS'($urandom_range(CODE_MAX)),
                                1'($urandom_range(1)));
                    sent++;
                end
                else
                begin
                    send_sample(CMD_CONVERT, pick_code(aim_x), pick_code(aim_y),
                                1'($urandom_range(1)));
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
